@@ rtl/core/fixed_point_reciprocal_core_defines.svh @@
// Assertion macros for the reciprocal core.
`ifndef FIXED_POINT_RECIPROCAL_CORE_DEFINES_SVH
`define FIXED_POINT_RECIPROCAL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FPR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FPR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fpr_pkg.sv @@
package fpr_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [15:0] GRID_LOW  = 16'd3276;
    localparam logic [15:0] GRID_HIGH = 16'd36044;
    localparam int          GRID_SHIFT = 9;
    localparam logic signed [13:0] ONE_SIXTH = 14'sd5461;

    // msb positions that bracket the normalized range
    localparam logic [4:0] LEAD_DOWN = 5'd15;
    localparam logic [4:0] LEAD_UP   = 5'd11;

    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        logic       neg;
        logic       zero;
        logic [3:0] up;
        logic [4:0] dn;
    } ctl_t;

    // 32768/x at grid points GRID_LOW + 512*i, U4.15
    localparam logic [18:0] RECIP_ROM [TABLE_ENTRIES] = '{
        19'd327680, 19'd283398, 19'd249660, 19'd223101,
        19'd201649, 19'd183960, 19'd169125, 19'd156503,
        19'd145635, 19'd136178, 19'd127875, 19'd120525,
        19'd113975, 19'd108100, 19'd102801, 19'd97997,
        19'd93622,  19'd89621,  19'd85948,  19'd82565,
        19'd79437,  19'd76538,  19'd73843,  19'd71331,
        19'd68985,  19'd66788,  19'd64726,  19'd62788,
        19'd60963,  19'd59241,  19'd57614,  19'd56073,
        19'd54613,  19'd53227,  19'd51909,  19'd50655,
        19'd49461,  19'd48321,  19'd47233,  19'd46192,
        19'd45197,  19'd44243,  19'd43329,  19'd42452,
        19'd41610,  19'd40800,  19'd40021,  19'd39272,
        19'd38550,  19'd37854,  19'd37183,  19'd36535,
        19'd35910,  19'd35305,  19'd34721,  19'd34155,
        19'd33608,  19'd33078,  19'd32564,  19'd32066,
        19'd31583,  19'd31115,  19'd30660,  19'd30218
    };

endpackage

@@ rtl/core/fixed_point_reciprocal_core.sv @@
// Channel  | Direction | Ports                                   | Payload
// ---------+-----------+-----------------------------------------+----------------------------
// operand  | in        | s_valid, s_ready, s_x_value             | S16.15 signed operand
// result   | out       | m_valid, m_ready, m_recip_value, m_status | S16.15 reciprocal, status
//
// 17-stage pipeline: one transfer per cycle in each direction while m_ready is high.
// Depth is set by the RK4 chain: four squarings and five scaled products, one
// multiplier per stage, plus normalization and shift-back stages.
// Synchronous active-low reset clears only the stage valid bits.
// Stalls: each stage holds while its successor is full and stalled; empty stages
// fill behind a stalled output, so s_ready stays high until the pipeline is full.
module fixed_point_reciprocal_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_x_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_recip_value,
    output logic [1:0]           m_status
);
    import fpr_pkg::*;

    localparam int NS = 17;   // register stages, stage NS-1 is the output register

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] ld;

    always_comb begin
        ld[NS-1] = !v_reg[NS-1] || m_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
        v_next[0] = ld[0] ? s_valid : v_reg[0];
        for (int i = 1; i < NS; i++) begin
            v_next[i] = ld[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = ld[0];
    assign m_valid = v_reg[NS-1];

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    ctl_t                ctl_reg [0:15];
    logic [31:0]         mag0_reg, mag1_reg;
    logic [4:0]          lead1_reg;
    logic [15:0]         mc2_reg;
    logic [4:0]          amt2_reg;
    logic                isdn2_reg, isup2_reg;
    logic [15:0]         m3_reg;
    logic signed [20:0]  yc_reg [4:13];     // ROM seed, carried to the final add
    logic [8:0]          hc_reg [4:12];     // step from grid point
    logic signed [23:0]  k1_reg [5:9];
    logic signed [20:0]  y2_reg;
    logic signed [23:0]  k2_reg [7:9];
    logic signed [20:0]  y3_reg;
    logic signed [23:0]  k3_reg;
    logic signed [20:0]  y4_reg;
    logic signed [26:0]  s_reg [10:11];     // k1 + 2k2 + 2k3
    logic signed [23:0]  k4_reg;
    logic signed [26:0]  sum_reg;
    logic signed [21:0]  p1_reg;
    logic signed [21:0]  r_reg;
    logic [30:0]         mag15_reg;
    logic                sat15_reg;
    logic signed [31:0]  out_reg;
    status_t             st_reg;

    // ------------------------------------------------------------------
    // Next-value logic, grouped by stage
    // ------------------------------------------------------------------
    ctl_t                ctl0_next;
    logic [31:0]         mag0_next;
    logic [4:0]          lead1_next;
    logic [15:0]         mc2_next;
    logic [4:0]          amt2_next;
    logic                isdn2_next, isup2_next;
    logic [15:0]         m3_next;
    ctl_t                ctl3_next;
    logic [15:0]         diff4;
    logic signed [20:0]  y4seed_next;
    logic signed [41:0]  sq5, sq7, sq9, sq11;
    logic signed [23:0]  k1_next, k2_next, k3_next, k4_next;
    logic signed [9:0]   hs6, hs8, hs10, hs13;
    logic signed [33:0]  prod6, prod8, prod10;
    logic signed [20:0]  y2_next, y3_next, y4_next;
    logic signed [26:0]  s10_next, sum_next;
    logic signed [36:0]  prod13;
    logic signed [35:0]  prod14;
    logic signed [21:0]  r_next;
    logic [20:0]         rc15;
    logic [33:0]         wide15;
    logic                sat15_next;
    logic [30:0]         mag15_next;
    logic signed [31:0]  out_next;
    status_t             st_next;

    // stage 0: magnitude; the most negative operand maps to 2^31
    always_comb begin
        mag0_next      = s_x_value[31] ? (~s_x_value + 32'd1) : s_x_value;
        ctl0_next.neg  = s_x_value[31];
        ctl0_next.zero = (s_x_value == 32'sd0);
        ctl0_next.up   = '0;
        ctl0_next.dn   = '0;
    end

    // stage 1: leading-one position
    always_comb begin
        lead1_next = '0;
        for (int i = 0; i < 32; i++) begin
            if (mag0_reg[i]) begin
                lead1_next = 5'(i);
            end
        end
    end

    // stage 2: coarse shift puts the msb at bit 15 (down) or bit 11 (up)
    always_comb begin
        isdn2_next = 1'b0;
        isup2_next = 1'b0;
        amt2_next  = '0;
        mc2_next   = mag1_reg[15:0];
        if (lead1_reg >= LEAD_DOWN) begin
            isdn2_next = 1'b1;
            amt2_next  = lead1_reg - LEAD_DOWN;
            mc2_next   = 16'(mag1_reg >> amt2_next);
        end else if (lead1_reg <= LEAD_UP) begin
            isup2_next = 1'b1;
            amt2_next  = LEAD_UP - lead1_reg;
            mc2_next   = mag1_reg[15:0] << amt2_next;
        end
    end

    // stage 3: one more step where the coarse value sits outside the range
    always_comb begin
        ctl3_next    = ctl_reg[2];
        ctl3_next.up = '0;
        ctl3_next.dn = '0;
        m3_next      = mc2_reg;
        if (isdn2_reg) begin
            if (mc2_reg >= GRID_HIGH) begin
                m3_next      = mc2_reg >> 1;
                ctl3_next.dn = amt2_reg + 5'd1;
            end else begin
                ctl3_next.dn = amt2_reg;
            end
        end else if (isup2_reg) begin
            if (mc2_reg < GRID_LOW) begin
                m3_next      = mc2_reg << 1;
                ctl3_next.up = amt2_reg[3:0] + 4'd1;
            end else begin
                ctl3_next.up = amt2_reg[3:0];
            end
        end
    end

    // stage 4: table seed and step
    always_comb begin
        diff4       = m3_reg - GRID_LOW;
        y4seed_next = $signed({2'b00, RECIP_ROM[diff4[GRID_SHIFT +: IDX_W]]});
    end

    // stages 5..11: RK4 along dy/dx = -y^2, floor scaling on every product
    always_comb begin
        sq5     = yc_reg[4] * yc_reg[4];
        k1_next = -$signed({1'b0, sq5[37:15]});

        hs6     = $signed({1'b0, hc_reg[5]});
        prod6   = hs6 * (k1_reg[5] >>> 1);
        y2_next = yc_reg[5] + 21'($signed(prod6[33:15]));

        sq7     = y2_reg * y2_reg;
        k2_next = -$signed({1'b0, sq7[37:15]});

        hs8     = $signed({1'b0, hc_reg[7]});
        prod8   = hs8 * (k2_reg[7] >>> 1);
        y3_next = yc_reg[7] + 21'($signed(prod8[33:15]));

        sq9     = y3_reg * y3_reg;
        k3_next = -$signed({1'b0, sq9[37:15]});

        hs10     = $signed({1'b0, hc_reg[9]});
        prod10   = hs10 * k3_reg;
        y4_next  = yc_reg[9] + 21'($signed(prod10[33:15]));
        s10_next = 27'(k1_reg[9]) + (27'(k2_reg[9]) <<< 1) + (27'(k3_reg) <<< 1);

        sq11    = y4_reg * y4_reg;
        k4_next = -$signed({1'b0, sq11[37:15]});
    end

    // stages 12..14: weighted sum, times h, times one sixth and added to the seed
    always_comb begin
        sum_next = s_reg[11] + 27'(k4_reg);
        hs13     = $signed({1'b0, hc_reg[12]});
        prod13   = hs13 * sum_reg;
        prod14   = p1_reg * ONE_SIXTH;
        r_next   = 22'(yc_reg[13]) + 22'($signed(prod14[35:15]));
    end

    // stage 15: clamp at zero, undo normalization, saturate
    always_comb begin
        rc15       = r_reg[21] ? 21'd0 : r_reg[20:0];
        wide15     = ({13'd0, rc15} << ctl_reg[14].up) >> ctl_reg[14].dn;
        sat15_next = |wide15[33:31];
        mag15_next = sat15_next ? MAX_POS[30:0] : wide15[30:0];
    end

    // stage 16: sign and status
    always_comb begin
        if (ctl_reg[15].zero) begin
            out_next = $signed(MAX_POS);
            st_next  = ST_ZERO;
        end else begin
            out_next = ctl_reg[15].neg ? -$signed({1'b0, mag15_reg})
                                       :  $signed({1'b0, mag15_reg});
            st_next  = sat15_reg ? ST_SAT : ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers, loaded by stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            ctl_reg[0] <= ctl0_next;
            mag0_reg   <= mag0_next;
        end
        if (ld[1]) begin
            ctl_reg[1] <= ctl_reg[0];
            mag1_reg   <= mag0_reg;
            lead1_reg  <= lead1_next;
        end
        if (ld[2]) begin
            ctl_reg[2] <= ctl_reg[1];
            mc2_reg    <= mc2_next;
            amt2_reg   <= amt2_next;
            isdn2_reg  <= isdn2_next;
            isup2_reg  <= isup2_next;
        end
        if (ld[3]) begin
            ctl_reg[3] <= ctl3_next;
            m3_reg     <= m3_next;
        end
        for (int i = 4; i < 16; i++) begin
            if (ld[i]) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
        if (ld[4]) begin
            yc_reg[4] <= y4seed_next;
            hc_reg[4] <= diff4[8:0];
        end
        for (int i = 5; i < 14; i++) begin
            if (ld[i]) begin
                yc_reg[i] <= yc_reg[i-1];
            end
        end
        for (int i = 5; i < 13; i++) begin
            if (ld[i]) begin
                hc_reg[i] <= hc_reg[i-1];
            end
        end
        if (ld[5]) begin
            k1_reg[5] <= k1_next;
        end
        for (int i = 6; i < 10; i++) begin
            if (ld[i]) begin
                k1_reg[i] <= k1_reg[i-1];
            end
        end
        if (ld[6]) begin
            y2_reg <= y2_next;
        end
        if (ld[7]) begin
            k2_reg[7] <= k2_next;
        end
        if (ld[8]) begin
            k2_reg[8] <= k2_reg[7];
            y3_reg    <= y3_next;
        end
        if (ld[9]) begin
            k2_reg[9] <= k2_reg[8];
            k3_reg    <= k3_next;
        end
        if (ld[10]) begin
            y4_reg     <= y4_next;
            s_reg[10]  <= s10_next;
        end
        if (ld[11]) begin
            k4_reg    <= k4_next;
            s_reg[11] <= s_reg[10];
        end
        if (ld[12]) begin
            sum_reg <= sum_next;
        end
        if (ld[13]) begin
            p1_reg <= $signed(prod13[36:15]);
        end
        if (ld[14]) begin
            r_reg <= r_next;
        end
        if (ld[15]) begin
            mag15_reg <= mag15_next;
            sat15_reg <= sat15_next;
        end
        if (ld[16]) begin
            out_reg <= out_next;
            st_reg  <= st_next;
        end
    end

    assign m_recip_value = out_reg;
    assign m_status      = st_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `include "fixed_point_reciprocal_core_defines.svh"

    `FPR_ASSERT_SAME(a_no_min_neg, aclk, aresetn, m_valid, m_recip_value != 32'sh8000_0000, "result is -2^31")
    `FPR_ASSERT_SAME(a_zero_max, aclk, aresetn, m_valid && (m_status == ST_ZERO), m_recip_value == $signed(MAX_POS), "zero operand without max result")
    `FPR_ASSERT_SAME(a_norm_range, aclk, aresetn, v_reg[3] && !ctl_reg[3].zero, (m3_reg >= GRID_LOW) && (m3_reg < GRID_HIGH), "normalized operand out of range")
    `FPR_ASSERT_NEXT(a_first_stage, aclk, aresetn, s_valid && s_ready, v_reg[0], "accepted operand lost at first stage")

endmodule
